@@ rtl/jittered_2d_sample_generator_macros.svh @@
// Assertion macros for the jittered 2-D sample generator.
// Used by the top level; needs clk and rst_n in the scope of each use.
`ifndef JITTERED_2D_SAMPLE_GENERATOR_MACROS_SVH
`define JITTERED_2D_SAMPLE_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define JSG_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jsg assertion failed");
// next-cycle implication
`define JSG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jsg assertion failed");
`else
`define JSG_ASSERT_SAME(lbl, ante, cons)
`define JSG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/jsg_pkg.sv @@
// Shared types and constants of the jittered 2-D sample generator.
// No dependencies; used by the result interface, controller, datapath and top level.
package jsg_pkg;

  localparam int SIDE_W     = 7;
  localparam int SEED_W     = 48;
  localparam int FRAC_W     = 24;
  localparam int IDX_W      = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 48;
  localparam int CHUNK_W    = 2;
  localparam int STEP_W     = 5;

  localparam int MAX_SIDE_DEF = 64;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd4;
  localparam logic [SEED_W-1:0] SEED_RESET = 48'd20017429951246;
  localparam logic [34:0]       LCG_MUL    = 35'h5DEECE66D;
  localparam logic [SEED_W-1:0] LCG_ADD    = 48'hB;

  // six multiply chunks (three per draw), then one divide step per fraction bit
  localparam logic [STEP_W-1:0] DRAW_LAST = 5'd5;
  localparam logic [STEP_W-1:0] DRAW_HALF = 5'd3;
  localparam logic [STEP_W-1:0] DIV_LAST  = 5'(FRAC_W - 1);

  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIDE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RNG_SEED  = 1'd1;

  localparam logic [CHUNK_W-1:0] CHUNK_LO  = 2'd0;
  localparam logic [CHUNK_W-1:0] CHUNK_MID = 2'd1;
  localparam logic [CHUNK_W-1:0] CHUNK_HI  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic               start;
    logic               mul_en;
    logic [CHUNK_W-1:0] mul_chunk;
    logic               mul_second;
    logic               div_en;
    logic               out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

endpackage

@@ rtl/jsg_in_if.sv @@
// Request channel of the sample generator: valid/ready plus the restart flag.
// Depends on nothing.
interface jsg_in_if ();
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

@@ rtl/jsg_out_if.sv @@
// Result channel of the sample generator: valid/ready plus one sample.
// Depends on jsg_pkg for the field widths.
interface jsg_out_if import jsg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [FRAC_W-1:0]       x_frac;
  logic [FRAC_W-1:0]       y_frac;
  logic [IDX_W-1:0]        row_index;
  logic [IDX_W-1:0]        col_index;
  logic                    last_of_pattern;

  modport source (output valid, output x_frac, output y_frac, output row_index,
                  output col_index, output last_of_pattern, input ready);
  modport sink (input valid, input x_frac, input y_frac, input row_index,
                input col_index, input last_of_pattern, output ready);
endinterface

@@ rtl/jsg_ctrl.sv @@
// Sequencer of the sample generator: accepts a request, steps the generator
// multiply and the two dividers, then hands the sample over. Uses jsg_pkg.
module jsg_ctrl import jsg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   cnt_r, cnt_nxt;
  logic [STEP_W-1:0]   cnt_m3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          state_nxt = ST_DRAW;
        end
      end
      ST_DRAW: begin
        if (cnt_r == DRAW_LAST) begin
          state_nxt = ST_DIV;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_DIV: begin
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_FIN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!stat.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  assign cnt_m3 = cnt_r - DRAW_HALF;

  // outputs
  always_comb begin
    in_ready       = 1'b0;
    cmd.start      = 1'b0;
    cmd.mul_en     = 1'b0;
    cmd.mul_chunk  = CHUNK_LO;
    cmd.mul_second = 1'b0;
    cmd.div_en     = 1'b0;
    cmd.out_load   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_DRAW: begin
        cmd.mul_en = 1'b1;
        if (cnt_r < DRAW_HALF) begin
          cmd.mul_chunk = cnt_r[CHUNK_W-1:0];
        end else begin
          cmd.mul_chunk  = cnt_m3[CHUNK_W-1:0];
          cmd.mul_second = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_en = 1'b1;
      end
      ST_FIN: begin
        cmd.out_load = !stat.out_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/jsg_dp.sv @@
// Datapath of the sample generator: config registers, stratum counters,
// chunked 48-bit generator multiply, two bit-serial dividers, output register.
// Uses jsg_pkg; driven by jsg_ctrl through dp_cmd_t.
module jsg_dp import jsg_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic                  in_restart,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [FRAC_W-1:0]     out_x_frac,
  output logic [FRAC_W-1:0]     out_y_frac,
  output logic [IDX_W-1:0]      out_row_index,
  output logic [IDX_W-1:0]      out_col_index,
  output logic                  out_last_of_pattern
);

  localparam int CNT_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int CMP_W = ((CNT_W > SIDE_W) ? CNT_W : SIDE_W) + 1;

  logic [SIDE_W-1:0] grid_side_r;
  logic [SEED_W-1:0] rng_r, rng_nxt;
  logic [SEED_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]  row_r, col_r;
  logic [CNT_W-1:0]  row_cur_r, col_cur_r;
  logic              last_r;
  logic [SIDE_W-1:0] side_r;

  logic [SIDE_W-1:0] remx_r, remy_r;
  logic [FRAC_W-1:0] qx_r, qy_r;

  logic              out_valid_r;
  logic [FRAC_W-1:0] out_x_r, out_y_r;
  logic [IDX_W-1:0]  out_row_r, out_col_r;
  logic              out_last_r;

  // effective side and stratum bookkeeping
  logic [SIDE_W-1:0] side_eff;
  logic [CMP_W-1:0]  side_w;
  logic              wrap;
  logic [CNT_W-1:0]  row_c, col_c;
  logic              col_end, row_end;

  always_comb begin
    if (grid_side_r == '0) begin
      side_eff = SIDE_W'(1);
    end else if (CMP_W'(grid_side_r) > CMP_W'(MAX_SIDE)) begin
      side_eff = SIDE_W'(MAX_SIDE);
    end else begin
      side_eff = grid_side_r;
    end
    side_w  = CMP_W'(side_eff);
    wrap    = in_restart || (CMP_W'(row_r) >= side_w) || (CMP_W'(col_r) >= side_w);
    row_c   = wrap ? '0 : row_r;
    col_c   = wrap ? '0 : col_r;
    col_end = (CMP_W'(col_c) + CMP_W'(1)) >= side_w;
    row_end = (CMP_W'(row_c) + CMP_W'(1)) >= side_w;
  end

  // one 16-bit slice of the state times the multiplier per cycle
  logic [15:0]       x_slice;
  logic [50:0]       pp;
  logic [SEED_W-1:0] pp_sh;

  always_comb begin
    case (cmd.mul_chunk)
      CHUNK_LO:  x_slice = rng_r[15:0];
      CHUNK_MID: x_slice = rng_r[31:16];
      CHUNK_HI:  x_slice = rng_r[47:32];
      default:   x_slice = '0;
    endcase
    pp = 51'(x_slice) * 51'(LCG_MUL);
    case (cmd.mul_chunk)
      CHUNK_LO:  pp_sh = pp[47:0];
      CHUNK_MID: pp_sh = {pp[31:0], 16'd0};
      CHUNK_HI:  pp_sh = {pp[15:0], 32'd0};
      default:   pp_sh = '0;
    endcase
    acc_nxt = ((cmd.mul_chunk == CHUNK_LO) ? LCG_ADD : acc_r) + pp_sh;
  end

  always_comb begin
    rng_nxt = rng_r;
    if (cmd.mul_en && cmd.mul_chunk == CHUNK_HI) begin
      rng_nxt = acc_nxt;
    end
    if (cfg_we && cfg_index == REG_RNG_SEED) begin
      rng_nxt = cfg_data[SEED_W-1:0];
    end
  end

  // restoring divide step: remainder stays below side
  logic [SIDE_W:0]   tx, ty;
  logic              gex, gey;
  logic [SIDE_W-1:0] remx_nxt, remy_nxt;

  always_comb begin
    tx       = {remx_r, qx_r[FRAC_W-1]};
    ty       = {remy_r, qy_r[FRAC_W-1]};
    gex      = tx >= {1'b0, side_r};
    gey      = ty >= {1'b0, side_r};
    remx_nxt = gex ? SIDE_W'(tx - {1'b0, side_r}) : tx[SIDE_W-1:0];
    remy_nxt = gey ? SIDE_W'(ty - {1'b0, side_r}) : ty[SIDE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_side_r <= SIDE_RESET;
      rng_r       <= SEED_RESET;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rng_r <= rng_nxt;
      if (cfg_we && cfg_index == REG_GRID_SIDE) begin
        grid_side_r <= cfg_data[SIDE_W-1:0];
      end
      if (cmd.start) begin
        col_r <= col_end ? '0 : col_c + CNT_W'(1);
        if (col_end) begin
          row_r <= row_end ? '0 : row_c + CNT_W'(1);
        end else begin
          row_r <= row_c;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      row_cur_r <= row_c;
      col_cur_r <= col_c;
      last_r    <= col_end && row_end;
      side_r    <= side_eff;
    end
    if (cmd.mul_en) begin
      acc_r <= acc_nxt;
      if (cmd.mul_chunk == CHUNK_HI) begin
        if (!cmd.mul_second) begin
          qx_r   <= acc_nxt[SEED_W-1:SEED_W-FRAC_W];
          remx_r <= SIDE_W'(row_cur_r);
        end else begin
          qy_r   <= acc_nxt[SEED_W-1:SEED_W-FRAC_W];
          remy_r <= SIDE_W'(col_cur_r);
        end
      end
    end
    if (cmd.div_en) begin
      remx_r <= remx_nxt;
      remy_r <= remy_nxt;
      qx_r   <= {qx_r[FRAC_W-2:0], gex};
      qy_r   <= {qy_r[FRAC_W-2:0], gey};
    end
    if (cmd.out_load) begin
      out_x_r    <= qx_r;
      out_y_r    <= qy_r;
      out_row_r  <= IDX_W'(row_cur_r);
      out_col_r  <= IDX_W'(col_cur_r);
      out_last_r <= last_r;
    end
  end

  assign stat.out_busy       = out_valid_r && !out_ready;
  assign out_valid           = out_valid_r;
  assign out_x_frac          = out_x_r;
  assign out_y_frac          = out_y_r;
  assign out_row_index       = out_row_r;
  assign out_col_index       = out_col_r;
  assign out_last_of_pattern = out_last_r;

endmodule

@@ rtl/jittered_2d_sample_generator.sv @@
// Jittered stratified 2-D sample generator.
// A request on in_chan (restart = 1 begins a new pattern at row 0, column 0)
// yields one sample on out_chan: x_frac, y_frac as 0.24 fractions, the
// stratum row and column, and last_of_pattern on the final sample, after
// which the row/column counters wrap. Strata go in row-major order.
// Each request steps a 48-bit linear congruential generator twice; each step
// is three 16 x 35-bit partial products. The two coordinates are then divided
// by the grid side in two restoring dividers that run side by side, one
// quotient bit per cycle. The sample is loaded in the FIN state once the
// output register is free; only then does the controller return to idle
// and accept a new request. in_chan.ready is high only while idle.
// The finished sample sits in an output register, so a stalled receiver does
// not block the next request; only the load of the following sample waits.
// Config: cfg_index 0 sets grid_side (0 acts as 1, above MAX_SIDE saturates),
// index 1 loads the generator state. Write only while idle.
// Synchronous reset: grid_side 4, default seed, counters zero, no result.
`include "jittered_2d_sample_generator_macros.svh"
module jittered_2d_sample_generator import jsg_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  jsg_in_if.sink                in_chan,
  jsg_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  jsg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  jsg_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_restart          (in_chan.restart),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_valid           (out_chan.valid),
    .out_ready           (out_chan.ready),
    .out_x_frac          (out_chan.x_frac),
    .out_y_frac          (out_chan.y_frac),
    .out_row_index       (out_chan.row_index),
    .out_col_index       (out_chan.col_index),
    .out_last_of_pattern (out_chan.last_of_pattern)
  );

  // a new sample must never overwrite one still waiting
  `JSG_ASSERT_SAME(a_no_result_overwrite, cmd.out_load, !stat.out_busy)
  // one item in flight at a time
  `JSG_ASSERT_NEXT(a_busy_after_accept, in_chan.valid && in_chan.ready, !in_chan.ready)
  // multiplier and dividers never share a cycle
  `JSG_ASSERT_SAME(a_mul_div_exclusive, cmd.mul_en, !cmd.div_en)

endmodule
